// ===== src/udp_payload_timestamp_inserter_assert.svh =====
// ----------------------------------------------------------------------------
// udp_payload_timestamp_inserter_assert.svh
// assertion macros for the timestamp inserter
// ----------------------------------------------------------------------------
`ifndef UDP_PAYLOAD_TIMESTAMP_INSERTER_ASSERT_SVH
`define UDP_PAYLOAD_TIMESTAMP_INSERTER_ASSERT_SVH

// same-cycle implication
`define UTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/udp_ts_pkg.sv =====
// ----------------------------------------------------------------------------
// udp_ts_pkg
// types and fixed frame offsets for the udp timestamp inserter
// ----------------------------------------------------------------------------
package udp_ts_pkg;

   // fixed header layout: ethernet, 20 byte ipv4, udp
   localparam int HOLD_START      = 40;
   localparam int POS_ETYPE_HI    = 12;
   localparam int POS_ETYPE_LO    = 13;
   localparam int POS_PROTO       = 23;
   localparam int POS_DPORT_HI    = 36;
   localparam int POS_DPORT_LO    = 37;
   localparam int TIME_BYTES      = 8;
   localparam int CSUM_BYTES      = 2;

   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;
   localparam logic [15:0] PORT_RESET = 16'd5000;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [63:0] time_ns;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   typedef struct packed {
      logic shift;
      logic rewrite;
   } chain_ctl_type;

   typedef enum logic {
      ST_RUN,
      ST_FLUSH
   } state_type;

endpackage

// ===== src/udp_ts_cell.sv =====
// ----------------------------------------------------------------------------
// udp_ts_cell
// one byte of the holdback line, takes its neighbor's byte or an override byte on a shift
// ----------------------------------------------------------------------------
module udp_ts_cell (
   input  logic       clock,
   input  logic       shift_en,
   input  logic       ovr_en,
   input  logic [7:0] nbr_byte,
   input  logic [7:0] ovr_byte,
   output logic [7:0] cell_byte
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (shift_en) begin
         byte_in = ovr_en ? ovr_byte : nbr_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cell_byte = byte_ff;

endmodule

// ===== src/udp_ts_chain.sv =====
// ----------------------------------------------------------------------------
// udp_ts_chain
// row of holdback cells; bytes enter at the tail and leave at the head
// ----------------------------------------------------------------------------
module udp_ts_chain #(
   parameter int DEPTH = 18
) (
   input  logic                     clock,
   input  udp_ts_pkg::chain_ctl_type ctl,
   input  logic [7:0]               tail_byte,
   input  logic [63:0]              frame_time,
   output logic [7:0]               head_byte
);

   localparam int TIME_IDX = DEPTH - udp_ts_pkg::TIME_BYTES;

   logic [7:0] cell_q [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [7:0] nbr;
      logic [7:0] ovr;
      logic       ovr_en;

      if (i == DEPTH - 1) begin : g_tail
         assign nbr = tail_byte;
      end else begin : g_mid
         assign nbr = cell_q[i+1];
      end

      // checksum cleared, timestamp little-endian at the end of the window
      if (i < udp_ts_pkg::CSUM_BYTES) begin : g_csum
         assign ovr    = 8'h00;
         assign ovr_en = ctl.rewrite;
      end else if (i >= TIME_IDX) begin : g_time
         assign ovr    = frame_time[8*(i-TIME_IDX) +: 8];
         assign ovr_en = ctl.rewrite;
      end else begin : g_keep
         assign ovr    = nbr;
         assign ovr_en = 1'b0;
      end

      udp_ts_cell u_cell (
         .clock     (clock),
         .shift_en  (ctl.shift),
         .ovr_en    (ovr_en),
         .nbr_byte  (nbr),
         .ovr_byte  (ovr),
         .cell_byte (cell_q[i])
      );
   end

   assign head_byte = cell_q[0];

endmodule

// ===== src/udp_payload_timestamp_inserter.sv =====
// bypass: a byte outside the holdback window is loaded straight into the output register when taken
// throughput: one byte per cycle while the output is not stalled, except after the window
// closes (byte 57 or a frame end inside it): then the 18-cell line flushes, input stalled
// reset: synchronous; clears position, captures, flush state, output valid and
// sets the match port to 5000; holdback cells are not reset
// ----------------------------------------------------------------------------
// udp_payload_timestamp_inserter
// byte-stream ingress timestamp insertion for matching udp frames
// ----------------------------------------------------------------------------
`include "udp_payload_timestamp_inserter_assert.svh"

module udp_payload_timestamp_inserter #(
   parameter int HOLD_DEPTH = 18
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  udp_ts_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output udp_ts_pkg::rsp_type rsp_data,
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data
);

   localparam int HOLD_END = udp_ts_pkg::HOLD_START + HOLD_DEPTH - 1;
   localparam int POS_SAT  = HOLD_END + 1;
   localparam int POS_W    = $clog2(POS_SAT + 1);
   localparam int CNT_W    = $clog2(HOLD_DEPTH);

   udp_ts_pkg::state_type     state_ff, state_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic [15:0]               etype_ff, etype_in;
   logic [7:0]                proto_ff, proto_in;
   logic [15:0]               dport_ff, dport_in;
   logic [63:0]               ftime_ff, ftime_in;
   logic [15:0]               port_ff, port_in;
   logic [CNT_W-1:0]          flush_cnt_ff, flush_cnt_in;
   logic [CNT_W-1:0]          skip_ff, skip_in;
   logic                      fin_last_ff, fin_last_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   udp_ts_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   udp_ts_pkg::chain_ctl_type ctl;
   logic [7:0]                head_byte;
   logic                      out_free;
   logic                      accept;
   logic                      in_window;
   logic                      at_end;
   logic                      match;
   logic                      out_load;
   logic                      emit;
   logic                      step;
   udp_ts_pkg::rsp_type       out_word;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == udp_ts_pkg::ST_RUN) && out_free);
   assign accept    = req_valid && !req_stall;

   assign in_window = (pos_ff >= POS_W'(udp_ts_pkg::HOLD_START)) &&
                      (pos_ff <= POS_W'(HOLD_END));
   assign at_end    = (pos_ff == POS_W'(HOLD_END));
   assign match     = (etype_ff == udp_ts_pkg::ETYPE_IPV4) &&
                      (proto_ff == udp_ts_pkg::PROTO_UDP) &&
                      (dport_ff == port_ff);

   // header captures and frame bookkeeping
   always_comb begin
      pos_in   = pos_ff;
      etype_in = etype_ff;
      proto_in = proto_ff;
      dport_in = dport_ff;
      ftime_in = ftime_ff;
      port_in  = csr_wr_en ? csr_wr_data : port_ff;
      if (accept) begin
         if (pos_ff == '0) begin
            ftime_in = req_data.time_ns;
         end
         if (pos_ff == POS_W'(udp_ts_pkg::POS_ETYPE_HI)) begin
            etype_in[15:8] = req_data.data_byte;
         end
         if (pos_ff == POS_W'(udp_ts_pkg::POS_ETYPE_LO)) begin
            etype_in[7:0] = req_data.data_byte;
         end
         if (pos_ff == POS_W'(udp_ts_pkg::POS_PROTO)) begin
            proto_in = req_data.data_byte;
         end
         if (pos_ff == POS_W'(udp_ts_pkg::POS_DPORT_HI)) begin
            dport_in[15:8] = req_data.data_byte;
         end
         if (pos_ff == POS_W'(udp_ts_pkg::POS_DPORT_LO)) begin
            dport_in[7:0] = req_data.data_byte;
         end
         if (req_data.last_byte) begin
            pos_in = '0;
         end else if (pos_ff < POS_W'(POS_SAT)) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // run / flush control and output register load
   always_comb begin
      state_in     = state_ff;
      flush_cnt_in = flush_cnt_ff;
      skip_in      = skip_ff;
      fin_last_in  = fin_last_ff;
      ctl          = '0;
      out_load     = 1'b0;
      out_word     = '0;
      emit         = 1'b0;
      step         = 1'b0;
      case (state_ff)
         udp_ts_pkg::ST_RUN: begin
            if (accept) begin
               if (in_window) begin
                  ctl.shift = 1'b1;
                  if (at_end || req_data.last_byte) begin
                     ctl.rewrite  = at_end && match;
                     state_in     = udp_ts_pkg::ST_FLUSH;
                     flush_cnt_in = '0;
                     // cells ahead of the oldest held byte are stale
                     skip_in      = CNT_W'(POS_W'(HOLD_END) - pos_ff);
                     fin_last_in  = req_data.last_byte;
                  end
               end else begin
                  out_load          = 1'b1;
                  out_word.out_byte = req_data.data_byte;
                  out_word.out_last = req_data.last_byte;
               end
            end
         end
         udp_ts_pkg::ST_FLUSH: begin
            emit = (flush_cnt_ff >= skip_ff);
            step = !emit || out_free;
            if (step) begin
               ctl.shift    = 1'b1;
               flush_cnt_in = flush_cnt_ff + 1'b1;
               if (emit) begin
                  out_load          = 1'b1;
                  out_word.out_byte = head_byte;
                  out_word.out_last = fin_last_ff &&
                                      (flush_cnt_ff == CNT_W'(HOLD_DEPTH - 1));
               end
               if (flush_cnt_ff == CNT_W'(HOLD_DEPTH - 1)) begin
                  state_in = udp_ts_pkg::ST_RUN;
               end
            end
         end
         default: begin
            state_in = udp_ts_pkg::ST_RUN;
         end
      endcase
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = out_load ? out_word : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= udp_ts_pkg::ST_RUN;
         pos_ff       <= '0;
         etype_ff     <= '0;
         proto_ff     <= '0;
         dport_ff     <= '0;
         ftime_ff     <= '0;
         port_ff      <= udp_ts_pkg::PORT_RESET;
         flush_cnt_ff <= '0;
         skip_ff      <= '0;
         fin_last_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         etype_ff     <= etype_in;
         proto_ff     <= proto_in;
         dport_ff     <= dport_in;
         ftime_ff     <= ftime_in;
         port_ff      <= port_in;
         flush_cnt_ff <= flush_cnt_in;
         skip_ff      <= skip_in;
         fin_last_ff  <= fin_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   udp_ts_chain #(
      .DEPTH (HOLD_DEPTH)
   ) u_chain (
      .clock      (clock),
      .ctl        (ctl),
      .tail_byte  (req_data.data_byte),
      .frame_time (ftime_ff),
      .head_byte  (head_byte)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `UTS_ASSERT_NEXT(a_window_close_flush, clock, reset, accept && at_end, (state_ff == udp_ts_pkg::ST_FLUSH) && (flush_cnt_ff == '0), "window close did not start a flush")
   `UTS_ASSERT_NOW(a_flush_blocks_input, clock, reset, state_ff == udp_ts_pkg::ST_FLUSH, req_stall, "word taken during holdback flush")
   `UTS_ASSERT_NEXT(a_frame_end_rewinds, clock, reset, accept && req_data.last_byte, pos_ff == '0, "byte position not cleared at frame end")
   `UTS_ASSERT_NOW(a_flush_load_free, clock, reset, out_load, out_free, "output register overwritten while held")

endmodule
